>>> hdl/msb_pkg.sv
// Shared constants, types and codes of the monotonic branch splitter.
package msb_pkg;

  // Build-time sizing of the block.
  localparam int MAX_RUN_LENGTH = 65536;
  localparam int TEMP_BITS      = 32;

  // Widths of the port fields.
  localparam int TEMP_W = 32;
  localparam int IDX_W  = 16;

  // The low EFF_BITS bits of a sample take part in the comparison; with these sizes that is all 32 bits.
  localparam int EFF_BITS = (TEMP_BITS < TEMP_W) ? TEMP_BITS : TEMP_W;

  // Sample indices stop counting at this value.
  localparam int IDX_LIMIT_INT = (MAX_RUN_LENGTH - 1 < 65535) ? MAX_RUN_LENGTH - 1 : 65535;
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(IDX_LIMIT_INT);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Direction of the open branch.
  typedef enum logic [2:0] {
    DIR_UNDET = 3'b001,
    DIR_HEAT  = 3'b010,
    DIR_COOL  = 3'b100
  } dir_t;

  // One queue entry: what one sample leaves to be emitted.
  typedef struct packed {
    logic             has_close;
    logic [IDX_W-1:0] close_start;
    logic [IDX_W-1:0] close_stop;
    logic             close_heat;
    logic             has_final;
    logic [IDX_W-1:0] final_start;
    logic [IDX_W-1:0] final_stop;
    logic             final_heat;
  } msb_rec_t;

  // Handshake between a queue and its two users.
  typedef struct packed {
    logic full;
    logic empty;
  } msb_qstat_t;

endpackage

>>> hdl/monotonic_branch_splitter_top.sv
// A sample's first branch word enters the queue when taken, then the output register.
// One sample per cycle while the queue has room; a two-branch sample gives two words.
// The four-entry queue between the front and the back lets a stalled output absorb samples.
// A sample that emits nothing never waits on the output side unless the queue is full.
// Reset (rst, synchronous, active high) empties the queue and the output register and
// makes the next sample the first of a new run.
module monotonic_branch_splitter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [msb_pkg::TEMP_W-1:0] temperature,
  input  logic                       last_sample,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  output logic [msb_pkg::IDX_W-1:0]  branch_start,
  output logic [msb_pkg::IDX_W-1:0]  branch_stop,
  output logic                       heating,
  output logic                       final_branch,
  output logic                       branch_valid,
  input  logic                       branch_stall
);
  import msb_pkg::*;

  logic       push;
  logic       pop;
  msb_rec_t   push_rec;
  msb_rec_t   head_rec;
  msb_qstat_t qstat;

  // Sample intake and branch tracking.
  msb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .temperature  (temperature),
    .last_sample  (last_sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .qstat        (qstat),
    .push         (push),
    .push_rec     (push_rec)
  );

  // Queue of emitted branch entries.
  msb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .qstat    (qstat)
  );

  // Output sequencing.
  msb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_rec     (head_rec),
    .qstat        (qstat),
    .pop          (pop),
    .branch_valid (branch_valid),
    .branch_stall (branch_stall),
    .branch_start (branch_start),
    .branch_stop  (branch_stop),
    .heating      (heating),
    .final_branch (final_branch)
  );

endmodule

>>> hdl/msb_front.sv
// Front part: accepts samples, tracks the open branch and queues emitted branches.
module msb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [msb_pkg::TEMP_W-1:0] temperature,
  input  logic                       last_sample,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  msb_pkg::msb_qstat_t        qstat,
  output logic                       push,
  output msb_pkg::msb_rec_t          push_rec
);
  import msb_pkg::*;

  logic signed [EFF_BITS-1:0] prev_temp;
  logic signed [EFF_BITS-1:0] prev_temp_next;
  dir_t                       dir;
  dir_t                       dir_next;
  logic [IDX_W-1:0]           begin_idx;
  logic [IDX_W-1:0]           begin_idx_next;
  logic [IDX_W-1:0]           sample_idx;
  logic [IDX_W-1:0]           sample_idx_next;
  logic                       awaiting_first;
  logic                       accept;
  logic signed [EFF_BITS-1:0] cur_temp;
  dir_t                       step_dir;
  msb_rec_t                   rec;

  // A sample is taken whenever the queue has room.
  assign sample_stall = qstat.full;
  assign accept       = sample_valid && !sample_stall;
  assign cur_temp     = $signed(temperature[EFF_BITS-1:0]);

  // Classify the step and work out the next branch state.
  always_comb begin
    dir_next        = dir;
    begin_idx_next  = begin_idx;
    sample_idx_next = sample_idx;
    prev_temp_next  = cur_temp;
    rec             = '0;
    if (cur_temp > prev_temp) begin
      step_dir = DIR_HEAT;
    end else if (cur_temp < prev_temp) begin
      step_dir = DIR_COOL;
    end else begin
      step_dir = DIR_UNDET;
    end
    if (awaiting_first) begin
      dir_next        = DIR_UNDET;
      begin_idx_next  = '0;
      sample_idx_next = '0;
    end else begin
      sample_idx_next = (sample_idx < IDX_LIMIT) ? sample_idx + IDX_W'(1) : IDX_LIMIT;
      if (step_dir != DIR_UNDET) begin
        if (dir == DIR_UNDET) begin
          dir_next = step_dir;
        end else if (step_dir != dir) begin
          // A reversal closes the branch at the previous sample.
          rec.has_close   = 1'b1;
          rec.close_start = begin_idx;
          rec.close_stop  = sample_idx;
          rec.close_heat  = (dir == DIR_HEAT);
          begin_idx_next  = sample_idx;
          dir_next        = step_dir;
        end
      end
    end
    rec.has_final   = last_sample;
    rec.final_start = begin_idx_next;
    rec.final_stop  = sample_idx_next;
    rec.final_heat  = (dir_next != DIR_COOL);
  end

  // Only samples that emit something take a queue entry.
  assign push     = accept && (rec.has_close || rec.has_final);
  assign push_rec = rec;

  // Run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir            <= DIR_UNDET;
      begin_idx      <= '0;
      sample_idx     <= '0;
      prev_temp      <= '0;
      awaiting_first <= 1'b1;
    end else if (accept) begin
      dir            <= dir_next;
      begin_idx      <= begin_idx_next;
      sample_idx     <= sample_idx_next;
      prev_temp      <= prev_temp_next;
      awaiting_first <= last_sample;
    end
  end

endmodule

>>> hdl/msb_queue.sv
// Short first-in first-out queue of branch entries between the front and the back.
module msb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  msb_pkg::msb_rec_t   push_rec,
  input  logic                pop,
  output msb_pkg::msb_rec_t   head_rec,
  output msb_pkg::msb_qstat_t qstat
);
  import msb_pkg::*;

  msb_rec_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head_rec    = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/msb_back.sv
// Back part: turns queue entries into branch words on the output register.
module msb_back (
  input  logic                      clk,
  input  logic                      rst,
  input  msb_pkg::msb_rec_t         head_rec,
  input  msb_pkg::msb_qstat_t       qstat,
  output logic                      pop,
  output logic                      branch_valid,
  input  logic                      branch_stall,
  output logic [msb_pkg::IDX_W-1:0] branch_start,
  output logic [msb_pkg::IDX_W-1:0] branch_stop,
  output logic                      heating,
  output logic                      final_branch
);
  import msb_pkg::*;

  logic             slot_free;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_start;
  logic [IDX_W-1:0] pend_stop;
  logic             pend_heat;

  // The output register can load when empty or when its word leaves now.
  assign slot_free = !branch_valid || !branch_stall;
  assign pop       = slot_free && !pend_valid && !qstat.empty;

  // Control: output valid and the held final branch.
  always_ff @(posedge clk) begin
    if (rst) begin
      branch_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (slot_free) begin
      if (pend_valid) begin
        branch_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else if (pop) begin
        branch_valid <= 1'b1;
        pend_valid   <= head_rec.has_close && head_rec.has_final;
      end else begin
        branch_valid <= 1'b0;
      end
    end
  end

  // Payload: a closed branch goes first, the final branch waits one word.
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_valid) begin
        branch_start <= pend_start;
        branch_stop  <= pend_stop;
        heating      <= pend_heat;
        final_branch <= 1'b1;
      end else if (pop) begin
        if (head_rec.has_close) begin
          branch_start <= head_rec.close_start;
          branch_stop  <= head_rec.close_stop;
          heating      <= head_rec.close_heat;
          final_branch <= 1'b0;
        end else begin
          branch_start <= head_rec.final_start;
          branch_stop  <= head_rec.final_stop;
          heating      <= head_rec.final_heat;
          final_branch <= 1'b1;
        end
        pend_start <= head_rec.final_start;
        pend_stop  <= head_rec.final_stop;
        pend_heat  <= head_rec.final_heat;
      end
    end
  end

endmodule
